[design/qvr_pkg.sv]
package qvr_pkg;

  typedef logic signed [31:0] vec_t;   // Q16.16
  typedef logic signed [15:0] quat_t;  // Q1.14
  typedef logic [15:0]        tol_t;   // units of 2^-28

  localparam tol_t        TOL_RESET = 16'd268;
  localparam logic [32:0] ONE_Q28   = 33'h1000_0000;

endpackage

[design/qvr_in_if.sv]
interface qvr_in_if;
  import qvr_pkg::*;

  logic  valid;
  logic  ready;
  vec_t  vec_x;
  vec_t  vec_y;
  vec_t  vec_z;
  quat_t quat_w;
  quat_t quat_x;
  quat_t quat_y;
  quat_t quat_z;

  modport source (output valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
                  input ready);
  modport sink   (input valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
                  output ready);
endinterface

[design/qvr_out_if.sv]
interface qvr_out_if;
  import qvr_pkg::*;

  logic valid;
  logic ready;
  vec_t rot_x;
  vec_t rot_y;
  vec_t rot_z;
  logic degenerate;
  logic saturated;

  modport source (output valid, rot_x, rot_y, rot_z, degenerate, saturated, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, degenerate, saturated, output ready);
endinterface

[design/qvr_cfg_if.sv]
interface qvr_cfg_if;
  import qvr_pkg::*;

  logic valid;
  logic ready;
  tol_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[design/quaternion_vector_rotate.sv]
// Quaternion vector rotation, fixed point.
// vec_in  : request carrying a Q16.16 vector and a Q1.14 quaternion (w, x, y, z).
// rot_out : rotated Q16.16 vector plus degenerate and saturated flags.
// cfg     : write channel for norm_tolerance (units of 2^-28); always ready.
//           Write it only while no request is in flight.
// If |w^2+x^2+y^2+z^2 - 1| exceeds the tolerance the quaternion is divided by
// its norm first (pipelined square root, then four pipelined dividers).
// An all-zero quaternion sets degenerate and returns the vector unchanged.
// Throughput: one request per cycle unless the output stalls; every request walks
// all 68 stages, set by the 31-stage square root and the 27-stage quotient pipeline.
// Stall: when a result waits on rot_out.ready low, the whole pipe freezes and
// vec_in.ready drops; nothing is lost or repeated.
// Reset: all stage valid bits clear, norm_tolerance returns to 268.
module quaternion_vector_rotate (
  input  logic          clk_i,
  input  logic          rst_ni,
  qvr_in_if.sink        vec_in,
  qvr_out_if.source     rot_out,
  qvr_cfg_if.sink       cfg
);
  import qvr_pkg::*;

  // stage map
  localparam int SQ_N   = 31;              // root digits
  localparam int DV_N   = 27;              // quotient bits
  localparam int ST_NRM = 1;
  localparam int ST_FLG = 2;
  localparam int ST_SQ0 = 3;
  localparam int ST_NUM = ST_SQ0 + SQ_N;
  localparam int ST_DV0 = ST_NUM + 1;
  localparam int ST_QW  = ST_DV0 + DV_N;
  localparam int ST_PA  = ST_QW + 1;
  localparam int ST_T   = ST_PA + 1;
  localparam int ST_PB  = ST_T + 1;
  localparam int ST_SUM = ST_PB + 1;
  localparam int ST_OUT = ST_SUM + 1;
  localparam int NST    = ST_OUT + 1;

  typedef struct packed {
    logic [2:0][31:0] v;
    logic [3:0][15:0] q;
    logic             renorm;
    logic             degen;
  } carry_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [30:0] root;
  } sq_st_t;

  typedef struct packed {
    logic [30:0] rem;
    logic [26:0] quo;
  } dv_st_t;

  // one digit of the floor square root of {norm2, 28'b0}
  function automatic sq_st_t sqrt_step(input sq_st_t st, input logic [32:0] nrm,
                                       input int pos);
    logic [61:0] n;
    logic [34:0] r2;
    logic [34:0] trial;
    sq_st_t      o;
    n     = {1'b0, nrm, 28'd0};
    r2    = {st.rem, n[2*pos +: 2]};
    trial = {2'b00, st.root, 2'b01};
    if (r2 >= trial) begin
      o.rem  = 33'(r2 - trial);
      o.root = {st.root[29:0], 1'b1};
    end else begin
      o.rem  = r2[32:0];
      o.root = {st.root[29:0], 1'b0};
    end
    return o;
  endfunction

  // one restoring division bit
  function automatic dv_st_t div_step(input dv_st_t st, input logic [55:0] num,
                                      input logic [30:0] s, input int pos);
    logic [31:0] r2;
    dv_st_t      o;
    r2 = {st.rem, num[pos]};
    if (r2 >= {1'b0, s}) begin
      o.rem = 31'(r2 - {1'b0, s});
      o.quo = {st.quo[25:0], 1'b1};
    end else begin
      o.rem = r2[30:0];
      o.quo = {st.quo[25:0], 1'b0};
    end
    return o;
  endfunction

  // divide by 2^25, round half away from zero
  function automatic logic signed [34:0] shr25(input logic signed [60:0] a);
    logic [60:0] mag;
    logic [60:0] r;
    mag = a[60] ? 61'(-a) : 61'(a);
    r   = (mag + 61'(2**24)) >> 25;
    return a[60] ? -$signed(r[34:0]) : $signed(r[34:0]);
  endfunction

  // divide by 2^26, round half away from zero
  function automatic logic signed [39:0] shr26(input logic signed [64:0] a);
    logic [64:0] mag;
    logic [64:0] r;
    mag = a[64] ? 65'(-a) : 65'(a);
    r   = (mag + 65'(2**25)) >> 26;
    return a[64] ? -$signed(r[39:0]) : $signed(r[39:0]);
  endfunction

  // ---------------------------------------------------------------------------
  // config and flow control
  // ---------------------------------------------------------------------------
  tol_t tol_q;
  logic en;
  logic [NST-1:0] vld_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg.valid) begin
      tol_q <= cfg.data;
    end
  end

  // whole pipe advances unless the output holds an untaken result
  assign en           = !vld_q[ST_OUT] || rot_out.ready;
  assign vec_in.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], vec_in.valid};
    end
  end

  // ---------------------------------------------------------------------------
  // side band: vector, raw quaternion, flags
  // ---------------------------------------------------------------------------
  carry_t carry_q [ST_SUM+1];
  carry_t carry_in;
  logic [33:0] dev_s;
  logic [33:0] dev_abs;
  logic        renorm_d;

  assign carry_in.v      = {vec_in.vec_z, vec_in.vec_y, vec_in.vec_x};
  assign carry_in.q      = {vec_in.quat_z, vec_in.quat_y, vec_in.quat_x, vec_in.quat_w};
  assign carry_in.renorm = 1'b0;
  assign carry_in.degen  = 1'b0;

  logic [32:0] nrm_q;

  assign dev_s    = {1'b0, nrm_q} - {1'b0, ONE_Q28};
  assign dev_abs  = dev_s[33] ? 34'(-dev_s) : dev_s;
  assign renorm_d = dev_abs > {18'd0, tol_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      carry_q[0] <= carry_in;
      for (int k = 1; k <= ST_SUM; k++) begin
        if (k == ST_FLG) begin
          carry_q[k] <= {carry_q[k-1].v, carry_q[k-1].q, renorm_d, (nrm_q == '0)};
        end else begin
          carry_q[k] <= carry_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // squared norm
  // ---------------------------------------------------------------------------
  logic signed [31:0] sqp [4];
  logic [30:0]        sq_q [4];
  logic [32:0]        nrm2_q;

  always_comb begin
    sqp[0] = vec_in.quat_w * vec_in.quat_w;
    sqp[1] = vec_in.quat_x * vec_in.quat_x;
    sqp[2] = vec_in.quat_y * vec_in.quat_y;
    sqp[3] = vec_in.quat_z * vec_in.quat_z;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) sq_q[i] <= sqp[i][30:0];
      nrm_q  <= 33'(sq_q[0]) + 33'(sq_q[1]) + 33'(sq_q[2]) + 33'(sq_q[3]);
      nrm2_q <= nrm_q;
    end
  end

  // ---------------------------------------------------------------------------
  // square root: one digit per stage
  // ---------------------------------------------------------------------------
  sq_st_t      sq_q_st [SQ_N];
  logic [32:0] sq_n_q  [SQ_N];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q_st[0] <= sqrt_step('0, nrm2_q, SQ_N-1);
      sq_n_q[0]  <= nrm2_q;
      for (int j = 1; j < SQ_N; j++) begin
        sq_q_st[j] <= sqrt_step(sq_q_st[j-1], sq_n_q[j-1], SQ_N-1-j);
        sq_n_q[j]  <= sq_n_q[j-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // dividend |raw|*2^40 + s/2
  // ---------------------------------------------------------------------------
  logic [30:0]         s_q;
  logic [3:0][55:0]    num_q;
  logic [3:0][15:0]    raw_abs;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      raw_abs[i] = carry_q[ST_NUM-1].q[i][15] ? 16'(-carry_q[ST_NUM-1].q[i])
                                              : carry_q[ST_NUM-1].q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q <= sq_q_st[SQ_N-1].root;
      for (int i = 0; i < 4; i++) begin
        num_q[i] <= {raw_abs[i], 40'd0} + 56'(sq_q_st[SQ_N-1].root >> 1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // four dividers: one quotient bit per stage
  // ---------------------------------------------------------------------------
  dv_st_t           dv_q     [DV_N][4];
  logic [55:0]      dv_num_q [DV_N][4];
  logic [30:0]      dv_s_q   [DV_N];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_s_q[0] <= s_q;
      for (int i = 0; i < 4; i++) begin
        dv_q[0][i]     <= div_step('{rem: {2'b00, num_q[i][55:27]}, quo: '0},
                                   num_q[i], s_q, DV_N-1);
        dv_num_q[0][i] <= num_q[i];
      end
      for (int j = 1; j < DV_N; j++) begin
        dv_s_q[j] <= dv_s_q[j-1];
        for (int i = 0; i < 4; i++) begin
          dv_q[j][i]     <= div_step(dv_q[j-1][i], dv_num_q[j-1][i], dv_s_q[j-1],
                                     DV_N-1-j);
          dv_num_q[j][i] <= dv_num_q[j-1][i];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // working quaternion, Q.26
  // ---------------------------------------------------------------------------
  logic signed [27:0] qw_q  [4];
  logic signed [27:0] qwa_q [4];
  logic signed [27:0] qwt_q [4];
  logic signed [27:0] qw_d  [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (carry_q[ST_QW-1].renorm) begin
        qw_d[i] = carry_q[ST_QW-1].q[i][15] ? -$signed({1'b0, dv_q[DV_N-1][i].quo})
                                            :  $signed({1'b0, dv_q[DV_N-1][i].quo});
      end else begin
        qw_d[i] = $signed({carry_q[ST_QW-1].q[i], 12'd0});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // rotation: t = 2*(qv x v), u = w*t + qv x t
  // ---------------------------------------------------------------------------
  logic signed [59:0] pa_q [6];
  logic signed [34:0] t_q  [3];
  logic signed [62:0] pb_q [9];
  logic signed [64:0] u_q  [3];
  logic signed [31:0] vs   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) vs[i] = $signed(carry_q[ST_QW].v[i]);
  end

  // qwa_q lines up with t_q's inputs, qwt_q with t_q itself
  always_ff @(posedge clk_i) begin
    if (en) begin
      qw_q  <= qw_d;
      qwa_q <= qw_q;
      qwt_q <= qwa_q;
      pa_q[0] <= qw_q[2] * vs[2];
      pa_q[1] <= qw_q[3] * vs[1];
      pa_q[2] <= qw_q[3] * vs[0];
      pa_q[3] <= qw_q[1] * vs[2];
      pa_q[4] <= qw_q[1] * vs[1];
      pa_q[5] <= qw_q[2] * vs[0];
      for (int i = 0; i < 3; i++) begin
        t_q[i] <= shr25(61'(pa_q[2*i]) - 61'(pa_q[2*i+1]));
      end
      pb_q[0] <= qwt_q[0] * t_q[0];
      pb_q[1] <= qwt_q[0] * t_q[1];
      pb_q[2] <= qwt_q[0] * t_q[2];
      pb_q[3] <= qwt_q[2] * t_q[2];
      pb_q[4] <= qwt_q[3] * t_q[1];
      pb_q[5] <= qwt_q[3] * t_q[0];
      pb_q[6] <= qwt_q[1] * t_q[2];
      pb_q[7] <= qwt_q[1] * t_q[1];
      pb_q[8] <= qwt_q[2] * t_q[0];
      u_q[0] <= 65'(pb_q[0]) + (65'(pb_q[3]) - 65'(pb_q[4]));
      u_q[1] <= 65'(pb_q[1]) + (65'(pb_q[5]) - 65'(pb_q[6]));
      u_q[2] <= 65'(pb_q[2]) + (65'(pb_q[7]) - 65'(pb_q[8]));
    end
  end

  // ---------------------------------------------------------------------------
  // final add, clamp, output register
  // ---------------------------------------------------------------------------
  logic signed [40:0] r_sum [3];
  logic [2:0]         clip;
  vec_t               r_clamp [3];
  vec_t               rot_q   [3];
  logic               degen_q;
  logic               sat_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_sum[i] = 41'($signed(carry_q[ST_SUM].v[i])) + 41'(shr26(u_q[i]));
      clip[i]  = (r_sum[i][40:31] != '0) && (r_sum[i][40:31] != '1);
      if (!clip[i])        r_clamp[i] = r_sum[i][31:0];
      else if (r_sum[i][40]) r_clamp[i] = 32'sh8000_0000;
      else                 r_clamp[i] = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      degen_q <= carry_q[ST_SUM].degen;
      if (carry_q[ST_SUM].degen) begin
        for (int i = 0; i < 3; i++) rot_q[i] <= carry_q[ST_SUM].v[i];
        sat_q <= 1'b0;
      end else begin
        rot_q <= r_clamp;
        sat_q <= |clip;
      end
    end
  end

  assign rot_out.valid      = vld_q[ST_OUT];
  assign rot_out.rot_x      = rot_q[0];
  assign rot_out.rot_y      = rot_q[1];
  assign rot_out.rot_z      = rot_q[2];
  assign rot_out.degenerate = degen_q;
  assign rot_out.saturated  = sat_q;

`ifndef ASSERT_OFF
  a_degen_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_out.valid && rot_out.degenerate |-> !rot_out.saturated)
    else $error("degenerate result flagged saturated");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_out.valid && !rot_out.ready |-> !vec_in.ready)
    else $error("input accepted while output stalled");

  a_sat_on_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_out.valid && rot_out.saturated |->
      (rot_out.rot_x == 32'sh7fff_ffff) || (rot_out.rot_x == 32'sh8000_0000) ||
      (rot_out.rot_y == 32'sh7fff_ffff) || (rot_out.rot_y == 32'sh8000_0000) ||
      (rot_out.rot_z == 32'sh7fff_ffff) || (rot_out.rot_z == 32'sh8000_0000))
    else $error("saturated flag without a clamped component");
`endif

endmodule

[tb/qvr_checker.sv]
module qvr_checker (
  input  logic clk_i,
  input  logic rst_ni,
  qvr_in_if    vec_mon,
  qvr_out_if   rot_mon,
  qvr_cfg_if   cfg_mon,
  output int   fail_cnt,
  output int   pending_cnt,
  output int   result_cnt
);
  import qvr_pkg::*;

  typedef struct packed {
    vec_t rx;
    vec_t ry;
    vec_t rz;
    logic degen;
    logic sat;
  } rot_res_t;

  rot_res_t rot_expq[$];
  tol_t     tol_q;

  // rounding shift, half away from zero
  function automatic longint rnd_shift(longint a, int k);
    longint half;
    half = longint'(1) << (k - 1);
    if (a < 0) return -(((-a) + half) >>> k);
    return (a + half) >>> k;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic rot_res_t rotate_vec(vec_t vx, vec_t vy, vec_t vz, quat_t qw,
                                          quat_t qx, quat_t qy, quat_t qz, tol_t tol);
    longint v[3], q[4], t[3], r[3];
    longint unsigned n2, s, mag, quo;
    longint dev;
    rot_res_t res;
    v[0] = vx; v[1] = vy; v[2] = vz;
    q[0] = qw; q[1] = qx; q[2] = qy; q[3] = qz;
    n2 = 0;
    for (int i = 0; i < 4; i++) n2 += longint'(q[i] * q[i]);
    res = '0;
    if (n2 == 0) begin
      res.rx = vx; res.ry = vy; res.rz = vz; res.degen = 1'b1;
      return res;
    end
    dev = longint'(n2) - (longint'(1) << 28);
    if (dev < 0) dev = -dev;
    if (dev > longint'(tol)) begin
      s = int_sqrt(n2 << 28);
      for (int i = 0; i < 4; i++) begin
        mag = (q[i] < 0) ? -q[i] : q[i];
        quo = ((mag << 40) + (s >> 1)) / s;
        q[i] = (q[i] < 0) ? -longint'(quo) : longint'(quo);
      end
    end else begin
      for (int i = 0; i < 4; i++) q[i] = q[i] * 4096;
    end
    t[0] = rnd_shift(q[2] * v[2] - q[3] * v[1], 25);
    t[1] = rnd_shift(q[3] * v[0] - q[1] * v[2], 25);
    t[2] = rnd_shift(q[1] * v[1] - q[2] * v[0], 25);
    r[0] = v[0] + rnd_shift(q[0] * t[0] + (q[2] * t[2] - q[3] * t[1]), 26);
    r[1] = v[1] + rnd_shift(q[0] * t[1] + (q[3] * t[0] - q[1] * t[2]), 26);
    r[2] = v[2] + rnd_shift(q[0] * t[2] + (q[1] * t[1] - q[2] * t[0]), 26);
    for (int i = 0; i < 3; i++) begin
      if (r[i] > 64'sd2147483647) begin
        r[i] = 64'sd2147483647; res.sat = 1'b1;
      end else if (r[i] < -64'sd2147483648) begin
        r[i] = -64'sd2147483648; res.sat = 1'b1;
      end
    end
    res.rx = r[0][31:0]; res.ry = r[1][31:0]; res.rz = r[2][31:0];
    return res;
  endfunction

  assign pending_cnt = rot_expq.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rot_res_t got, exp_r;
    if (!rst_ni) begin
      tol_q      <= TOL_RESET;
      fail_cnt   <= 0;
      result_cnt <= 0;
      rot_expq.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) tol_q <= cfg_mon.data;
      if (vec_mon.valid && vec_mon.ready)
        rot_expq.push_back(rotate_vec(vec_mon.vec_x, vec_mon.vec_y, vec_mon.vec_z,
                                      vec_mon.quat_w, vec_mon.quat_x, vec_mon.quat_y,
                                      vec_mon.quat_z, tol_q));
      if (rot_mon.valid && rot_mon.ready) begin
        result_cnt <= result_cnt + 1;
        got = '{rot_mon.rot_x, rot_mon.rot_y, rot_mon.rot_z,
                rot_mon.degenerate, rot_mon.saturated};
        if (rot_expq.size() == 0) begin
          $error("unexpected result: rot_x %0d rot_y %0d rot_z %0d",
                 got.rx, got.ry, got.rz);
          fail_cnt <= fail_cnt + 1;
        end else begin
          exp_r = rot_expq.pop_front();
          if (got != exp_r) fail_cnt <= fail_cnt + 1;
          if (got.rx !== exp_r.rx) $error("rot_x: expected %0d, got %0d", exp_r.rx, got.rx);
          if (got.ry !== exp_r.ry) $error("rot_y: expected %0d, got %0d", exp_r.ry, got.ry);
          if (got.rz !== exp_r.rz) $error("rot_z: expected %0d, got %0d", exp_r.rz, got.rz);
          if (got.degen !== exp_r.degen)
            $error("degenerate: expected %0b, got %0b", exp_r.degen, got.degen);
          if (got.sat !== exp_r.sat)
            $error("saturated: expected %0b, got %0b", exp_r.sat, got.sat);
        end
      end
    end
  end

endmodule

[tb/tb.sv]
module tb;
  import qvr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PIPE_DRAIN  = 100;
  localparam int RAND_ITEMS  = 470;   // per tolerance setting

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt, pending_cnt, result_cnt;
  int   cycle_cnt = 0;
  int   sent_cnt = 0;
  int   tol_writes = 0;
  bit   no_idle = 1'b0;   // stretches with neither side idling

  qvr_in_if  vec_in ();
  qvr_out_if rot_out ();
  qvr_cfg_if cfg ();

  quaternion_vector_rotate dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vec_in  (vec_in),
    .rot_out (rot_out),
    .cfg     (cfg)
  );

  qvr_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vec_mon     (vec_in),
    .rot_mon     (rot_out),
    .cfg_mon     (cfg),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt),
    .result_cnt  (result_cnt)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    vec_in.valid  = 1'b0;
    vec_in.vec_x  = '0;
    vec_in.vec_y  = '0;
    vec_in.vec_z  = '0;
    vec_in.quat_w = '0;
    vec_in.quat_x = '0;
    vec_in.quat_y = '0;
    vec_in.quat_z = '0;
    rot_out.ready = 1'b0;
    cfg.valid     = 1'b0;
    cfg.data      = '0;
  end

  // result side: random stall before taking each result
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        rot_out.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rot_out.ready <= 1'b1;
      do @(posedge clk_i); while (!rot_out.valid);
    end
  end

  // one request, with a random gap in front of it; valid stays up when no gap
  task automatic send_rot(vec_t vx, vec_t vy, vec_t vz,
                          quat_t qw, quat_t qx, quat_t qy, quat_t qz);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      vec_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    vec_in.valid  <= 1'b1;
    vec_in.vec_x  <= vx;
    vec_in.vec_y  <= vy;
    vec_in.vec_z  <= vz;
    vec_in.quat_w <= qw;
    vec_in.quat_x <= qx;
    vec_in.quat_y <= qy;
    vec_in.quat_z <= qz;
    do @(posedge clk_i); while (!vec_in.ready);
    sent_cnt++;
  endtask

  // park the request channel until the pipe has emptied
  task automatic drain_pipe();
    if (vec_in.valid) vec_in.valid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  // tolerance write, only with the pipe empty
  task automatic write_tol(tol_t val);
    drain_pipe();
    cfg.valid <= 1'b1;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    tol_writes++;
  endtask

  function automatic vec_t rand_vec();
    case ($urandom_range(0, 3))
      0:       return vec_t'($urandom);
      1:       return vec_t'($signed($urandom_range(0, 2 * 65536 * 16)) - 65536 * 16);
      2:       return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 255)
                                           : 32'sh80000000 + $urandom_range(0, 255);
      default: return vec_t'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic quat_t rand_small(int span);
    return quat_t'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // random request: mostly near-unit rotations, some arbitrary and edge quaternions
  task automatic send_random();
    quat_t qw, qx, qy, qz;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      // close to identity or a pure axis: norm lands near the tolerance band
      qw = quat_t'(16384 + rand_small(2));
      qx = rand_small(3); qy = rand_small(3); qz = rand_small(3);
      if (sel == 1) begin qw = rand_small(2); qz = quat_t'(-16384 + rand_small(2)); end
    end else if (sel < 6) begin
      // roughly unit magnitude at random angle
      qw = rand_small(11585); qx = rand_small(11585);
      qy = rand_small(11585); qz = rand_small(11585);
    end else if (sel < 9) begin
      qw = quat_t'($urandom); qx = quat_t'($urandom);
      qy = quat_t'($urandom); qz = quat_t'($urandom);
    end else begin
      // zero quaternion, or a lone extreme component
      qw = '0; qx = '0; qy = '0; qz = '0;
      case ($urandom_range(0, 4))
        1: qw = 16'sh8000;
        2: qx = 16'sh7fff;
        3: qy = 16'sh8000;
        4: qz = 16'sh0001;
        default: ;
      endcase
    end
    send_rot(rand_vec(), rand_vec(), rand_vec(), qw, qx, qy, qz);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
      // hold off once per phase until every result is back
      if (i == n / 2) drain_pipe();
      send_random();
    end
    no_idle = 1'b0;
  endtask

  localparam vec_t VMAX = 32'sh7fffffff;
  localparam vec_t VMIN = 32'sh80000000;

  initial begin
    tol_t tol_set[4];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, at the reset tolerance
    send_rot(32'sh00010000, 32'sh00020000, 32'sh00030000, 16'sd16384, 0, 0, 0); // identity
    send_rot(VMAX, VMIN, 32'sh12345678, 0, 0, 0, 0);                         // zero quaternion
    send_rot(VMIN, VMAX, 0, 0, 0, 0, 16'sd16384);          // half turn about z: clamps
    send_rot(VMAX, VMAX, VMAX, 0, 16'sd16384, 0, 0);       // half turn about x
    send_rot(32'sh00010000, 0, 0, 16'sd16384, 16'sd1, 0, 0); // non-unit, inside tolerance
    send_rot(32'sh00010000, 32'sh00010000, 0, 16'sd16384, 16'sd12, 16'sd12, 0); // just outside
    send_rot(32'sh00010000, 32'sh00010000, 32'sh00010000,
             16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);  // large norm, renormalized
    send_rot(VMIN, VMIN, VMIN, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_rot(VMAX, VMIN, VMAX, 16'sd11585, 0, 16'sd11585, 0); // quarter turn about y
    send_rot(32'sh00000001, 32'shffffffff, 0, 0, 0, 0, 16'sd1); // tiny quaternion
    send_rot(VMAX, 0, VMIN, 16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
    send_rot(0, 0, 0, 16'sd100, 16'sh8000, 16'sd3, 16'sh7fff);  // zero vector

    // random phases, each at its own tolerance
    tol_set = '{TOL_RESET, 16'd0, 16'hffff, tol_t'($urandom_range(1, 4000))};
    foreach (tol_set[k]) begin
      if (k > 0) write_tol(tol_set[k]);
      run_random(RAND_ITEMS);
    end

    vec_in.valid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (PIPE_DRAIN) @(posedge clk_i);

    $display("%0d rotations sent, %0d results checked, %0d tolerance writes",
             sent_cnt, result_cnt, tol_writes);
    $display("covered zero/unit/off-norm quaternions, clamping, stalls and idle gaps");
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
